// ===== hw/rtl/adaptive_fourier_analyzer_macros.svh =====
// Assertion macros shared by the checker of the adaptive Fourier analyzer.
`ifndef ADAPTIVE_FOURIER_ANALYZER_MACROS_SVH
`define ADAPTIVE_FOURIER_ANALYZER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define AFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/afa_pkg.sv =====
// Package of the adaptive Fourier analyzer: constants, types and arithmetic helpers.
package afa_pkg;

  localparam int HARMONICS    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int CNT_W        = $clog2(HARMONICS);
  localparam int PSUM_W       = 48;

  localparam logic signed [31:0] ONE_ROT  = 32'sd1073741824;
  localparam logic signed [63:0] INV_GAIN = 64'sd652032874;

  localparam logic [15:0] ALPHA_RST     = 16'd655;
  localparam logic [31:0] INIT_STEP_RST = 32'd4473924;
  localparam logic [15:0] GAIN_RST      = 16'd86;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_ALPHA     = 2'd1,
    REG_INIT_STEP = 2'd2,
    REG_FREQ_GAIN = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CELL_NOP   = 3'd0,
    CELL_CLEAR = 3'd1,
    CELL_GEN   = 3'd2,
    CELL_SUM   = 3'd3,
    CELL_UPD   = 3'd4
  } cell_op_t;

  // Broadcast control for the cell row.
  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] c1_re;
    logic signed [31:0] c1_im;
    logic signed [31:0] d;
  } afa_ctl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/afa_ifs.sv =====
// Handshake channel interfaces of the adaptive Fourier analyzer.
interface afa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface afa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] estimate;
  logic signed [15:0] error;
  modport source (output valid, output estimate, output error, input ready);
  modport sink (input valid, input estimate, input error, output ready);
endinterface

interface afa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/afa_cell.sv =====
// One harmonic cell: coefficient, rotator and running estimate sum.
module afa_cell
  import afa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     first,
  input  afa_ctl_t                 ctl,
  input  logic signed [31:0]       left_rot_re,
  input  logic signed [31:0]       left_rot_im,
  input  logic signed [PSUM_W-1:0] left_psum,
  output logic signed [31:0]       rot_re,
  output logic signed [31:0]       rot_im,
  output logic signed [PSUM_W-1:0] psum,
  output logic signed [31:0]       coef_re,
  output logic signed [31:0]       coef_im
);

  logic signed [31:0]       rot_re_r, rot_im_r, coef_re_r, coef_im_r;
  logic signed [PSUM_W-1:0] psum_r;
  logic signed [64:0]       gen_re, gen_im, term_full;
  logic signed [63:0]       upd_re, upd_im;
  logic signed [64:0]       gen_re_rnd, gen_im_rnd, term_rnd;
  logic signed [63:0]       upd_re_rnd, upd_im_rnd;

  assign rot_re  = first ? ONE_ROT : rot_re_r;
  assign rot_im  = first ? 32'sd0 : rot_im_r;
  assign psum    = psum_r;
  assign coef_re = coef_re_r;
  assign coef_im = coef_im_r;

  always_comb begin
    gen_re     = ctl.c1_re * left_rot_re - ctl.c1_im * left_rot_im;
    gen_im     = ctl.c1_re * left_rot_im + ctl.c1_im * left_rot_re;
    gen_re_rnd = (gen_re + 65'sd536870912) >>> 30;
    gen_im_rnd = (gen_im + 65'sd536870912) >>> 30;
    term_full  = rot_re * coef_re_r - rot_im * coef_im_r;
    term_rnd   = (term_full + 65'sd536870912) >>> 30;
    upd_re     = ctl.d * rot_re;
    upd_im     = ctl.d * rot_im;
    upd_re_rnd = (upd_re + 64'sd536870912) >>> 30;
    upd_im_rnd = (upd_im + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_re_r <= '0;
      coef_im_r <= '0;
    end else begin
      unique case (ctl.op)
        CELL_CLEAR: begin
          coef_re_r <= '0;
          coef_im_r <= '0;
        end
        CELL_UPD: begin
          coef_re_r <= sat32(64'(coef_re_r) + upd_re_rnd);
          coef_im_r <= sat32(64'(coef_im_r) - upd_im_rnd);
        end
        default: ;
      endcase
    end
  end

  // Rotator and partial sum registers load only on the generate and sum operations; they feed the right neighbor.
  always_ff @(posedge clk) begin
    if (ctl.op == CELL_GEN) begin
      rot_re_r <= gen_re_rnd[31:0];
      rot_im_r <= gen_im_rnd[31:0];
    end
    if (ctl.op == CELL_SUM) begin
      psum_r <= first ? PSUM_W'(coef_re_r)
                      : left_psum + (PSUM_W'($signed(term_rnd[34:0])) <<< 1);
    end
  end

endmodule

// ===== hw/rtl/afa_cordic.sv =====
// Iterative CORDIC shared for rotation and vectoring, one step per cycle.
module afa_cordic
  import afa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               vec_mode,
  input  logic signed [63:0] x0,
  input  logic signed [63:0] y0,
  input  logic signed [33:0] z0,
  output logic signed [63:0] x,
  output logic signed [63:0] y,
  output logic signed [33:0] z,
  output logic               done
);

  logic               busy_r, mode_r;
  logic [4:0]         i_r;
  logic signed [63:0] x_r, y_r, dx, dy;
  logic signed [33:0] z_r, t;
  logic               sigma;

  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
  // Done once every step has landed: the outputs are final in this cycle.
  assign done = busy_r && (i_r == 5'(CORDIC_N));

  always_comb begin
    dx    = y_r >>> i_r;
    dy    = x_r >>> i_r;
    t     = $signed({2'b00, atan_turn(i_r)});
    sigma = mode_r ? !(y_r > 64'sd0) : !z_r[33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
    end else if (busy_r) begin
      busy_r <= !done;
      i_r    <= i_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= vec_mode;
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
    end else if (busy_r && !done) begin
      if (sigma) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - t;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + t;
      end
    end
  end

endmodule

// ===== hw/rtl/adaptive_fourier_analyzer.sv =====
// Flow: while enabled, an accepted sample takes a CORDIC rotation pass, the rotator and sum
// ripples through the harmonic cell row and, when the angle measure is nonzero, a vectoring pass;
// while disabled it only clears; a result stall holds it. One sample is in work at a time, so
// throughput is set by the shared CORDIC (two passes) and the ripples through the cell row.
// Reset: synchronous, active low; clears coefficients and phase, loads the
// default registers and the start phase step.
module adaptive_fourier_analyzer
  import afa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  afa_in_if.sink    in_ch,
  afa_out_if.source out_ch,
  afa_cfg_if.sink   cfg_ch
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_CLR  = 12'b0000_0000_0010,
    S_ROT  = 12'b0000_0000_0100,
    S_C1   = 12'b0000_0000_1000,
    S_GEN  = 12'b0000_0001_0000,
    S_SUM  = 12'b0000_0010_0000,
    S_ERR  = 12'b0000_0100_0000,
    S_UPD  = 12'b0000_1000_0000,
    S_PQM  = 12'b0001_0000_0000,
    S_PQS  = 12'b0010_0000_0000,
    S_VEC  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic        enable_r;
  logic [15:0] alpha_r, gain_r;
  logic [31:0] init_step_r;

  // Observer state and per-sample working registers.
  logic [31:0]        phase_step_r, phase_accum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [15:0] smp_r;
  logic               flip_r, run_r;
  logic signed [31:0] c1_re_r, c1_im_r, d_r, ar_r, ai_r;
  logic signed [63:0] prod_r [4];
  logic signed [15:0] res_est_r, res_err_r;
  logic               out_valid_r;
  logic signed [15:0] out_est_r, out_err_r;

  // Cell row wiring: entry g feeds cell g, cell g drives entry g+1.
  afa_ctl_t                 ctl;
  logic signed [31:0]       rot_re_c [HARMONICS+1];
  logic signed [31:0]       rot_im_c [HARMONICS+1];
  logic signed [PSUM_W-1:0] psum_c   [HARMONICS+1];
  logic signed [31:0]       coef_re_a [HARMONICS];
  logic signed [31:0]       coef_im_a [HARMONICS];

  // CORDIC hookup.
  logic               cd_start, cd_vec, cd_done;
  logic signed [63:0] cd_x0, cd_y0, cd_x, cd_y;
  logic signed [33:0] cd_z0, cd_z;

  // Error path and frequency path combinational values.
  logic               accept, out_free;
  logic signed [63:0] y_full, e_full, e_ext, d_full, p_val, q_val, delta_full, neg_x, neg_y;
  logic signed [31:0] e_sat;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = out_est_r;
  assign out_ch.error    = out_err_r;

  assign rot_re_c[0] = '0;
  assign rot_im_c[0] = '0;
  assign psum_c[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < HARMONICS; g++) begin : g_cell
      afa_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .first       (1'(g == 0)),
        .ctl         (ctl),
        .left_rot_re (rot_re_c[g]),
        .left_rot_im (rot_im_c[g]),
        .left_psum   (psum_c[g]),
        .rot_re      (rot_re_c[g+1]),
        .rot_im      (rot_im_c[g+1]),
        .psum        (psum_c[g+1]),
        .coef_re     (coef_re_a[g]),
        .coef_im     (coef_im_a[g])
      );
    end
  endgenerate

  afa_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cd_start),
    .vec_mode (cd_vec),
    .x0       (cd_x0),
    .y0       (cd_y0),
    .z0       (cd_z0),
    .x        (cd_x),
    .y        (cd_y),
    .z        (cd_z),
    .done     (cd_done)
  );

  // Broadcast the operation for the cell row.
  always_comb begin
    ctl.c1_re = c1_re_r;
    ctl.c1_im = c1_im_r;
    ctl.d     = d_r;
    unique case (state_r)
      S_CLR:   ctl.op = CELL_CLEAR;
      S_GEN:   ctl.op = CELL_GEN;
      S_SUM:   ctl.op = CELL_SUM;
      S_UPD:   ctl.op = CELL_UPD;
      default: ctl.op = CELL_NOP;
    endcase
  end

  // Estimate, error and scaled error.
  always_comb begin
    y_full = 64'(psum_c[HARMONICS]);
    e_full = (64'(smp_r) <<< 13) - y_full;
    e_sat  = sat32(e_full);
    e_ext  = 64'(e_sat);
    d_full = (e_ext * $signed({48'd0, alpha_r}) + 64'sd32768) >>> 16;
  end

  // Angle measure between old and new fundamental, and the step correction.
  always_comb begin
    p_val      = (prod_r[0] >>> 3) + (prod_r[1] >>> 3);
    q_val      = (prod_r[2] >>> 3) - (prod_r[3] >>> 3);
    neg_x      = -cd_x;
    neg_y      = -cd_y;
    delta_full = (64'($signed(cd_z[31:0])) * $signed({48'd0, gain_r}) + 64'sd32768) >>> 16;
  end

  // Start the CORDIC: rotation on a running sample, vectoring on a nonzero angle measure.
  // Second and third quadrant phases move by half a turn; the result is negated later.
  always_comb begin
    cd_start = 1'b0;
    cd_vec   = 1'b0;
    cd_x0    = INV_GAIN;
    cd_y0    = '0;
    cd_z0    = 34'($signed(phase_accum_r ^
                           {phase_accum_r[31] ^ phase_accum_r[30], 31'd0}));
    if (state_r == S_IDLE) begin
      cd_start = accept && enable_r;
    end else if (state_r == S_PQS) begin
      cd_start = (p_val != 64'sd0) || (q_val != 64'sd0);
      cd_vec   = 1'b1;
      cd_x0    = p_val[63] ? -p_val : p_val;
      cd_y0    = p_val[63] ? -q_val : q_val;
      cd_z0    = p_val[63] ? $signed({2'b00, 32'h8000_0000}) : 34'sd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = enable_r ? S_ROT : S_CLR;
      S_CLR:  state_nxt = S_FIN;
      S_ROT:  if (cd_done) state_nxt = S_C1;
      S_C1:   state_nxt = (HARMONICS > 1) ? S_GEN : S_SUM;
      S_GEN:  if (cnt_r == CNT_W'(HARMONICS - 2)) state_nxt = S_SUM;
      S_SUM:  if (cnt_r == CNT_W'(HARMONICS - 1)) state_nxt = S_ERR;
      S_ERR:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_PQM;
      S_PQM:  state_nxt = (ar_r != 32'sd0 || ai_r != 32'sd0) ? S_PQS : S_FIN;
      S_PQS:  if (!cd_start) state_nxt = S_FIN;
              else state_nxt = S_VEC;
      S_VEC:  if (cd_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers, configuration and observer phase state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      enable_r      <= 1'b0;
      alpha_r       <= ALPHA_RST;
      init_step_r   <= INIT_STEP_RST;
      gain_r        <= GAIN_RST;
      phase_step_r  <= INIT_STEP_RST;
      phase_accum_r <= '0;
      out_valid_r   <= 1'b0;
      run_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (reg_idx_t'(cfg_ch.index))
          REG_ENABLE:    enable_r    <= cfg_ch.data[0];
          REG_ALPHA:     alpha_r     <= cfg_ch.data[15:0];
          REG_INIT_STEP: init_step_r <= cfg_ch.data;
          REG_FREQ_GAIN: gain_r      <= cfg_ch.data[15:0];
          default: ;
        endcase
      end

      // Count through the rotator and sum ripples; restart at each phase.
      if (state_r == S_GEN || state_r == S_SUM) begin
        cnt_r <= (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end

      if (state_r == S_IDLE && accept) run_r <= enable_r;

      // Disabled sample: reload the step and drop the phase.
      if (state_r == S_CLR) begin
        phase_step_r  <= init_step_r;
        phase_accum_r <= '0;
      end

      // Apply the frequency correction once the vectoring pass finishes.
      if (state_r == S_VEC && cd_done) begin
        phase_step_r <= phase_step_r + delta_full[31:0];
      end

      // Hand the result over and, after an enabled sample, advance the phase.
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (run_r) phase_accum_r <= phase_accum_r + phase_step_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      smp_r  <= in_ch.sample;
      flip_r <= phase_accum_r[31] ^ phase_accum_r[30];
    end
    if (state_r == S_C1) begin
      c1_re_r <= flip_r ? neg_x[31:0] : cd_x[31:0];
      c1_im_r <= flip_r ? neg_y[31:0] : cd_y[31:0];
    end
    if (state_r == S_CLR) begin
      res_est_r <= '0;
      res_err_r <= '0;
    end
    if (state_r == S_ERR) begin
      res_est_r <= sat16((y_full + 64'sd4096) >>> 13);
      res_err_r <= sat16((e_ext + 64'sd4096) >>> 13);
      d_r       <= d_full[31:0];
      ar_r      <= coef_re_a[1];
      ai_r      <= coef_im_a[1];
    end
    // Old fundamental held in ar/ai, new one now in cell one.
    if (state_r == S_PQM) begin
      prod_r[0] <= coef_re_a[1] * ar_r;
      prod_r[1] <= coef_im_a[1] * ai_r;
      prod_r[2] <= coef_im_a[1] * ar_r;
      prod_r[3] <= coef_re_a[1] * ai_r;
    end
    if (state_r == S_FIN && out_free) begin
      out_est_r <= res_est_r;
      out_err_r <= res_err_r;
    end
  end

endmodule

// ===== hw/rtl/afa_checker.sv =====
// Port-level checker of the adaptive Fourier analyzer, bound to the top level.
`include "adaptive_fourier_analyzer_macros.svh"

module afa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_estimate,
  input logic [15:0] out_error,
  input logic        cfg_ready
);

  // A stalled result stays offered and unchanged.
  `AFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_estimate) && $stable(out_error))

  // One sample in work at a time: no accept right after an accept.
  `AFA_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)

  // Configuration writes are never back-pressured.
  `AFA_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind adaptive_fourier_analyzer afa_checker u_afa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_estimate (out_ch.estimate),
  .out_error    (out_ch.error),
  .cfg_ready    (cfg_ch.ready)
);
